/* rtl/pic_pkg.sv */
package pic_pkg;

    localparam int COORD_BITS = 32;
    localparam int AXIS_BITS  = 18;
    localparam int LEN_BITS   = 31;
    localparam int FRAC_BITS  = 16;

    localparam int CFG_BITS     = (COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS;
    localparam int CFG_IDX_BITS = 3;

    // derived datapath widths
    localparam int D_BITS   = COORD_BITS + 1;
    localparam int P_BITS   = D_BITS + AXIS_BITS;
    localparam int SUM_BITS = P_BITS + 2;
    localparam int SH_BITS  = SUM_BITS - FRAC_BITS;
    localparam int LA_BITS  = LEN_BITS + 1;
    localparam int CMP_BITS = ((SH_BITS > LA_BITS) ? SH_BITS : LA_BITS) + 1;
    localparam int MP_BITS  = AXIS_BITS + LA_BITS;
    localparam int M_BITS   = MP_BITS - FRAC_BITS;
    localparam int L_BITS   = ((D_BITS > M_BITS) ? D_BITS : M_BITS) + 1;
    localparam int SQ_BITS  = 2 * LEN_BITS;
    localparam int ACC_BITS = SQ_BITS + 2;

    localparam int PIPE_DEPTH = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_Z = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd7;

    localparam logic signed [AXIS_BITS-1:0] AXIS_ONE = AXIS_BITS'(65536);

endpackage

/* rtl/point_in_cylinder_test.sv */
// Point-in-finite-cylinder test.
// Configuration: cfg_we/cfg_index/cfg_data write one of eight registers
// (base x/y/z, axis x/y/z, radius, height); write only while no request
// is in flight.
// Requests: a point (point_x/y/z) is taken on every clock edge with start
// high; busy is held low, so a new point may be given every cycle.
// Results: inside_res is presented with res_valid for one cycle, in request
// order. Throughput is one point per cycle through the 8-stage arithmetic
// pipeline (offset, dot product, sum, end tests, axis scaling, radial bound,
// squares, final compare).
// The receiver cannot stall, so the pipeline never holds.
// Reset (rst_n low) empties the pipeline and sets all registers to zero
// except axis_z, which becomes 1.0.
module point_in_cylinder_test
    import pic_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_BITS-1:0]   point_x,
    input  logic signed [COORD_BITS-1:0]   point_y,
    input  logic signed [COORD_BITS-1:0]   point_z,
    input  logic                           cfg_we,
    input  logic        [CFG_IDX_BITS-1:0] cfg_index,
    input  logic        [CFG_BITS-1:0]     cfg_data,
    output logic                           res_valid,
    output logic                           inside_res
);

    logic signed [COORD_BITS-1:0] base_reg [3];
    logic signed [AXIS_BITS-1:0]  axis_reg [3];
    logic        [LEN_BITS-1:0]   radius_reg;
    logic        [LEN_BITS-1:0]   height_reg;

    logic [PIPE_DEPTH:1] vld_reg;

    logic signed [D_BITS-1:0]   s1_d   [3];
    logic signed [D_BITS-1:0]   s2_d   [3];
    logic signed [D_BITS-1:0]   s3_d   [3];
    logic signed [D_BITS-1:0]   s4_d   [3];
    logic signed [D_BITS-1:0]   s5_d   [3];
    logic signed [P_BITS-1:0]   s2_p   [3];
    logic signed [SUM_BITS-1:0] s3_sum;
    logic signed [LA_BITS-1:0]  s4_la;
    logic                       s4_ok;
    logic signed [MP_BITS-1:0]  s5_mp  [3];
    logic                       s5_ok;
    logic        [LEN_BITS-1:0] s6_abs [3];
    logic                       s6_ok;
    logic        [SQ_BITS-1:0]  s7_sq  [3];
    logic        [SQ_BITS-1:0]  s7_rr;
    logic                       s7_ok;
    logic                       inside_res_reg;

    logic signed [SH_BITS-1:0]  sh;
    logic signed [CMP_BITS-1:0] sh_cmp;
    logic signed [CMP_BITS-1:0] h_neg;
    logic                       s4_ok_next;
    logic signed [M_BITS-1:0]   m_val  [3];
    logic signed [L_BITS-1:0]   l_val  [3];
    logic signed [L_BITS-1:0]   r_ext;
    logic        [2:0]          l_in;
    logic        [ACC_BITS-1:0] acc;

    assign busy       = 1'b0;
    assign res_valid  = vld_reg[PIPE_DEPTH];
    assign inside_res = inside_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                base_reg[i] <= '0;
            end
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= AXIS_ONE;
            radius_reg  <= '0;
            height_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_X: base_reg[0] <= cfg_data[COORD_BITS-1:0];
                REG_BASE_Y: base_reg[1] <= cfg_data[COORD_BITS-1:0];
                REG_BASE_Z: base_reg[2] <= cfg_data[COORD_BITS-1:0];
                REG_AXIS_X: axis_reg[0] <= cfg_data[AXIS_BITS-1:0];
                REG_AXIS_Y: axis_reg[1] <= cfg_data[AXIS_BITS-1:0];
                REG_AXIS_Z: axis_reg[2] <= cfg_data[AXIS_BITS-1:0];
                REG_RADIUS: radius_reg  <= cfg_data[LEN_BITS-1:0];
                REG_HEIGHT: height_reg  <= cfg_data[LEN_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-1:1], start};
        end
    end

    // end tests: la > 0, or la_q < -height
    always_comb
    begin
        sh         = SH_BITS'(s3_sum >>> FRAC_BITS);
        sh_cmp     = CMP_BITS'(sh);
        h_neg      = -CMP_BITS'($signed({1'b0, height_reg}));
        s4_ok_next = (s3_sum[SUM_BITS-1] || (s3_sum == '0)) && !(sh_cmp < h_neg);
    end

    // perpendicular offset and per-axis bound against the radius
    always_comb
    begin
        r_ext = L_BITS'($signed({1'b0, radius_reg}));
        for (int i = 0; i < 3; i++)
        begin
            m_val[i] = M_BITS'(s5_mp[i] >>> FRAC_BITS);
            l_val[i] = L_BITS'(s5_d[i]) - L_BITS'(m_val[i]);
            l_in[i]  = (l_val[i] < r_ext) && (-l_val[i] < r_ext);
        end
    end

    assign acc = ACC_BITS'(s7_sq[0]) + ACC_BITS'(s7_sq[1]) + ACC_BITS'(s7_sq[2]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_d[i] <= D_BITS'(base_reg[i]) - D_BITS'(i == 0 ? point_x :
                                                      i == 1 ? point_y : point_z);
            s2_p[i] <= P_BITS'(s1_d[i]) * P_BITS'(axis_reg[i]);
            s2_d[i] <= s1_d[i];
            s3_d[i] <= s2_d[i];
            s4_d[i] <= s3_d[i];
            s5_mp[i] <= MP_BITS'(axis_reg[i]) * MP_BITS'(s4_la);
            s5_d[i] <= s4_d[i];
            s6_abs[i] <= l_val[i][L_BITS-1] ? LEN_BITS'(-l_val[i]) : LEN_BITS'(l_val[i]);
            s7_sq[i] <= SQ_BITS'(s6_abs[i]) * SQ_BITS'(s6_abs[i]);
        end
        s3_sum <= SUM_BITS'(s2_p[0]) + SUM_BITS'(s2_p[1]) + SUM_BITS'(s2_p[2]);
        s4_la  <= LA_BITS'(sh);
        s4_ok  <= s4_ok_next;
        s5_ok  <= s4_ok;
        s6_ok  <= s5_ok && (&l_in);
        s7_ok  <= s6_ok;
        s7_rr  <= SQ_BITS'(radius_reg) * SQ_BITS'(radius_reg);
        inside_res_reg <= s7_ok && (acc < ACC_BITS'(s7_rr));
    end

    // a result only ever follows an accepted request
    a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(start, PIPE_DEPTH))
        else $error("result without a request");

    // a point that failed an early test never reports inside
    a_early_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[PIPE_DEPTH-1] && !s7_ok) |=> !inside_res)
        else $error("rejected point reported inside");

    // a point passing the end tests has a non-positive projection
    a_la_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[4] && s4_ok) |-> (s4_la[LA_BITS-1] || (s4_la == '0)))
        else $error("positive projection passed end test");

    // a point failing the radial bound is never reported inside
    a_radial: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[6] && !s6_ok) |=> ##1 !inside_res)
        else $error("radial bound ignored");

endmodule

/* sim/inside_checker.sv */
`timescale 1ns / 1ps

module inside_checker
    import pic_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic signed [COORD_BITS-1:0]   point_x,
    input  logic signed [COORD_BITS-1:0]   point_y,
    input  logic signed [COORD_BITS-1:0]   point_z,
    input  logic                           cfg_we,
    input  logic        [CFG_IDX_BITS-1:0] cfg_index,
    input  logic        [CFG_BITS-1:0]     cfg_data,
    input  logic                           res_valid,
    input  logic                           inside_res,
    output int                             fail_count,
    output int                             pending
);

    localparam int MAX_PRINTS = 20;

    typedef struct {
        int request_id;
        bit in_cyl;
    } verdict_t;

    // shadow copy of the cylinder registers
    logic signed [COORD_BITS-1:0] base_reg [3];
    logic signed [AXIS_BITS-1:0]  axis_reg [3];
    logic        [LEN_BITS-1:0]   radius_reg;
    logic        [LEN_BITS-1:0]   height_reg;

    verdict_t inside_q [$];
    int       request_cnt;

    initial begin
        fail_count  = 0;
        pending     = 0;
        request_cnt = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // d = base - p, proj = d.n in Q.32; outside when proj > 0, past the top or off the radius.
    function automatic bit point_inside(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] pz
    );
        longint           ofs [3];
        longint           nrm [3];
        longint           proj, proj_q, rad, hgt, along, perp;
        longint unsigned  sumsq;
        bit               ok;
        int               i;
        ofs[0] = longint'(base_reg[0]) - longint'(px);
        ofs[1] = longint'(base_reg[1]) - longint'(py);
        ofs[2] = longint'(base_reg[2]) - longint'(pz);
        proj = 0;
        for (i = 0; i < 3; i++)
        begin
            nrm[i] = longint'(axis_reg[i]);
            proj += ofs[i] * nrm[i];
        end
        rad    = longint'(radius_reg);
        hgt    = longint'(height_reg);
        proj_q = proj >>> FRAC_BITS;   // floor to Q.16
        ok     = 1'b1;
        sumsq  = 0;
        if (proj > 0)
            ok = 1'b0;
        else if (-proj_q > hgt)
            ok = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            if (ok)
            begin
                along = (nrm[i] * proj_q) >>> FRAC_BITS;
                perp  = ofs[i] - along;
                if (perp >= rad || -perp >= rad)
                    ok = 1'b0;
                else
                    sumsq += longint'(unsigned'(perp * perp));
            end
        end
        if (ok && !(sumsq < longint'(unsigned'(rad * rad))))
            ok = 1'b0;
        return ok;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp_v;
        verdict_t got_v;
        if (!rst_n)
        begin
            base_reg[0] = '0;
            base_reg[1] = '0;
            base_reg[2] = '0;
            axis_reg[0] = '0;
            axis_reg[1] = '0;
            axis_reg[2] = AXIS_ONE;
            radius_reg  = '0;
            height_reg  = '0;
            inside_q.delete();
            pending     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_X: base_reg[0] = cfg_data[COORD_BITS-1:0];
                    REG_BASE_Y: base_reg[1] = cfg_data[COORD_BITS-1:0];
                    REG_BASE_Z: base_reg[2] = cfg_data[COORD_BITS-1:0];
                    REG_AXIS_X: axis_reg[0] = cfg_data[AXIS_BITS-1:0];
                    REG_AXIS_Y: axis_reg[1] = cfg_data[AXIS_BITS-1:0];
                    REG_AXIS_Z: axis_reg[2] = cfg_data[AXIS_BITS-1:0];
                    REG_RADIUS: radius_reg  = cfg_data[LEN_BITS-1:0];
                    REG_HEIGHT: height_reg  = cfg_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                exp_v.request_id = request_cnt;
                exp_v.in_cyl     = point_inside(point_x, point_y, point_z);
                inside_q.push_back(exp_v);
                request_cnt++;
            end
            if (res_valid)
            begin
                if (inside_q.size() == 0)
                    report_mismatch($sformatf("result inside_res=%0b with no request open",
                                              inside_res));
                else
                begin
                    got_v = inside_q.pop_front();
                    if (inside_res !== got_v.in_cyl)
                        report_mismatch($sformatf("request %0d: inside_res=%0b, predicted %0b",
                                                  got_v.request_id, inside_res, got_v.in_cyl));
                end
            end
            pending <= inside_q.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import pic_pkg::*;

    localparam int     CYCLE_LIMIT = 300000;
    localparam int     ONE         = 65536;   // 1.0 in Q16.16
    localparam int     PHASES      = 13;
    localparam int     PHASE_ITEMS = 50;

    // 1/sqrt(3) in Q1.16
    localparam logic signed [AXIS_BITS-1:0] INV_SQRT3 = AXIS_BITS'(37837);

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [COORD_BITS-1:0]  point_x = '0;
    logic signed [COORD_BITS-1:0]  point_y = '0;
    logic signed [COORD_BITS-1:0]  point_z = '0;
    logic                          cfg_we = 1'b0;
    logic        [CFG_IDX_BITS-1:0] cfg_index = REG_BASE_X;
    logic        [CFG_BITS-1:0]    cfg_data = '0;
    logic                          res_valid;
    logic                          inside_res;

    int     fail_count;
    int     pending;
    bit     bursty = 1'b0;
    longint cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    point_in_cylinder_test dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .inside_res (inside_res)
    );

    inside_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .inside_res (inside_res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint rand_signed(input longint unsigned mag);
        longint v;
        v = longint'($urandom_range(0, mag[31:0]));
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    task automatic send_point(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] pz
    );
        int gap;
        gap = 0;
        if (bursty && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // leaves cfg_we high so back-to-back writes need no lowering in between
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_cylinder(
        input logic signed [COORD_BITS-1:0] bx,
        input logic signed [COORD_BITS-1:0] by,
        input logic signed [COORD_BITS-1:0] bz,
        input logic signed [AXIS_BITS-1:0]  ax,
        input logic signed [AXIS_BITS-1:0]  ay,
        input logic signed [AXIS_BITS-1:0]  az,
        input logic        [LEN_BITS-1:0]   rad,
        input logic        [LEN_BITS-1:0]   hgt
    );
        drain();
        write_reg(REG_BASE_X, bx);
        write_reg(REG_BASE_Y, by);
        write_reg(REG_BASE_Z, bz);
        write_reg(REG_AXIS_X, CFG_BITS'(ax));
        write_reg(REG_AXIS_Y, CFG_BITS'(ay));
        write_reg(REG_AXIS_Z, CFG_BITS'(az));
        write_reg(REG_RADIUS, CFG_BITS'(rad));
        write_reg(REG_HEIGHT, CFG_BITS'(hgt));
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n_items, input int flavor);
        logic signed [COORD_BITS-1:0] bsel [3];
        logic signed [AXIS_BITS-1:0]  nsel [3];
        logic        [LEN_BITS-1:0]   rad, hgt;
        longint                       pc [3];
        longint                       tmp, t, w, lim, lr, rr;
        longint unsigned              span;
        int                           s, k, j, axis_mode;
        s    = $urandom_range(4, 28);
        span = 64'd1 << s;
        for (j = 0; j < 3; j++)
        begin
            tmp = rand_signed(span);
            if ($urandom_range(0, 3) == 0)
                bsel[j] = $urandom;
            else
                bsel[j] = tmp[COORD_BITS-1:0];
        end
        rad = LEN_BITS'($urandom_range(0, span[31:0] * 2));
        hgt = LEN_BITS'($urandom_range(0, span[31:0] * 2));
        if ($urandom_range(0, 4) == 0)
            rad = LEN_BITS'($urandom);
        case (flavor)
            0:
            begin
                rad = '1;
                hgt = '1;
            end
            1: rad = '0;
            2: hgt = '0;
            default: ;
        endcase
        axis_mode = $urandom_range(0, 5);
        for (j = 0; j < 3; j++)
            nsel[j] = '0;
        case (axis_mode)
            0, 1, 2: nsel[axis_mode] = ($urandom_range(0, 1) != 0) ? AXIS_ONE : -AXIS_ONE;
            3:
            begin
                for (j = 0; j < 3; j++)
                    nsel[j] = ($urandom_range(0, 1) != 0) ? INV_SQRT3 : -INV_SQRT3;
            end
            4:
            begin
                for (j = 0; j < 3; j++)
                begin
                    tmp     = rand_signed(ONE);
                    nsel[j] = tmp[AXIS_BITS-1:0];
                end
            end
            default: ;   // zero axis
        endcase
        set_cylinder(bsel[0], bsel[1], bsel[2], nsel[0], nsel[1], nsel[2], rad, hgt);

        for (k = 0; k < n_items; k++)
        begin
            // most points land near the cylinder: base + n*t + jitter
            lim = longint'(hgt) + longint'(hgt) / 8;
            t   = longint'($urandom_range(0, lim[31:0])) - longint'(hgt) / 16;
            lr  = longint'(rad);
            rr  = ($urandom_range(0, 1) != 0) ? lr / 2 + lr / 8 : lr + lr / 8;
            for (j = 0; j < 3; j++)
            begin
                if ($urandom_range(0, 3) == 0)
                    pc[j] = longint'($signed($urandom));
                else
                begin
                    w     = rand_signed(rr);
                    pc[j] = longint'(bsel[j]) + ((longint'(nsel[j]) * t) >>> FRAC_BITS) + w;
                end
            end
            send_point(pc[0][COORD_BITS-1:0], pc[1][COORD_BITS-1:0], pc[2][COORD_BITS-1:0]);
        end
    endtask

    initial
    begin
        int p;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup: zero radius, nothing is inside
        send_point(0, 0, 0);
        send_point(0, 0, ONE);

        // upright cylinder at the origin, r = 10, h = 20
        set_cylinder(0, 0, 0, 0, 0, AXIS_ONE, LEN_BITS'(10 * ONE), LEN_BITS'(20 * ONE));
        send_point(0, 0, 5 * ONE);
        send_point(0, 0, 0);
        send_point(0, 0, 20 * ONE);
        send_point(0, 0, 20 * ONE + 1);
        send_point(0, 0, -1);
        send_point(10 * ONE, 0, 5 * ONE);
        send_point(10 * ONE - 1, 0, 5 * ONE);
        send_point(7 * ONE, 7 * ONE, ONE);
        send_point(8 * ONE, 7 * ONE, ONE);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);

        // zero height along x: only the base plane passes
        set_cylinder(0, 0, 0, AXIS_ONE, 0, 0, LEN_BITS'(5 * ONE), 0);
        send_point(0, ONE, ONE);
        send_point(1, 0, 0);
        send_point(-1, 0, 0);

        // tiny axis: projection below one LSB on either side
        set_cylinder(0, 0, 0, 1, 0, 0, LEN_BITS'(ONE), LEN_BITS'(100 * ONE));
        send_point(-1, 0, 0);
        send_point(1, 0, 0);

        // zero axis, extreme base, largest radius and height
        set_cylinder(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, '1, '1);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, -1);

        // axis far from unit length, negative component
        set_cylinder(-3 * ONE, 2 * ONE, ONE, AXIS_ONE, AXIS_ONE, -AXIS_ONE,
                     LEN_BITS'(4 * ONE), LEN_BITS'(8 * ONE));
        send_point(-3 * ONE, 2 * ONE, ONE);
        send_point(-2 * ONE, 3 * ONE, 0);
        send_point(-ONE, 4 * ONE, -ONE);

        for (p = 0; p < PHASES; p++)
        begin
            bursty = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            random_phase(PHASE_ITEMS, p);
        end

        drain();
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/pic_pkg.sv
rtl/point_in_cylinder_test.sv
sim/inside_checker.sv
sim/tb.sv
